// ===== src/dcfr_pkg.sv =====
// Shared types and constants for the dibit clocked frame receiver.
`timescale 1ns / 1ps

package dcfr_pkg;

  // Field widths.
  localparam int unsigned LIMIT_W = 20;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned DIBITS_PER_BYTE_W = 2;

  // Reset value of the timeout limit register.
  localparam logic [LIMIT_W-1:0] TIMEOUT_RESET = 20'd100000;

  // Receiver mode.
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_RECV  = 2'd1,
    MODE_DRAIN = 2'd2
  } mode_t;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_DATA    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd2;

  // One result item.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] byte_index;
    logic              last;
  } result_t;

endpackage

// ===== src/dibit_clocked_frame_receiver.sv =====
// Top level of the dibit clocked frame receiver.
`timescale 1ns / 1ps

// Channel   | Direction | Payload
// s_axis    | in        | tdata[0] clock_level, [1] data_hi, [2] data_lo, [7:3] zero
// m_axis    | out       | tdata[7:0] data_byte, [15:8] byte_index; tuser kind; tlast last
// cfg       | in        | cfg_data[19:0] timeout_limit
//
// The frame state is updated and the result written to the output or skid register
// at the edge that accepts a sample; one is taken every cycle while s_axis_tready is high.
// The result register is backed by one skid register; s_axis_tready drops only while
// the skid register holds a result that m_axis has not yet taken.
// Synchronous reset returns the receiver to idle, empties both result registers and
// loads the timeout limit with 100000. Configuration writes are taken at any time.
module dibit_clocked_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] clock_level, [1] data_hi, [2] data_lo
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [15:8] byte_index
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [19:0] cfg_data        // [19:0] timeout_limit
);
  import dcfr_pkg::*;

  // Configuration and frame state.
  logic [LIMIT_W-1:0]           timeout_limit;
  mode_t                        mode, mode_next;
  logic                         expected_level, expected_level_next;
  logic [DIBITS_PER_BYTE_W-1:0] dibit_count, dibit_count_next;
  logic [BYTE_W-1:0]            shift_byte, shift_byte_next;
  logic                         header_pending, header_pending_next;
  logic [BYTE_W-1:0]            frame_length, frame_length_next;
  logic [BYTE_W-1:0]            bytes_received, bytes_received_next;
  logic [LIMIT_W-1:0]           wait_count, wait_count_next;

  // Result registers.
  result_t out_reg, skid_reg, result_new;
  logic    out_valid, skid_valid, result_fire;

  logic s_fire, m_fire;
  logic ck, hi, lo;
  logic [BYTE_W-1:0] byte_assembled;
  logic              is_last;

  assign ck = s_axis_tdata[0];
  assign hi = s_axis_tdata[1];
  assign lo = s_axis_tdata[2];

  assign s_axis_tready = ~skid_valid;
  assign s_fire        = s_axis_tvalid & s_axis_tready;
  assign m_fire        = out_valid & m_axis_tready;
  assign cfg_ready     = 1'b1;

  assign byte_assembled = {shift_byte[BYTE_W-3:0], hi, lo};
  assign is_last = ({1'b0, bytes_received} + 9'd1) >= {1'b0, frame_length};

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_limit <= cfg_data;
    end
  end

  // Next mode and frame state for the sample at the input.
  always_comb begin
    mode_next           = mode;
    expected_level_next = expected_level;
    dibit_count_next    = dibit_count;
    shift_byte_next     = shift_byte;
    header_pending_next = header_pending;
    frame_length_next   = frame_length;
    bytes_received_next = bytes_received;
    wait_count_next     = wait_count;
    case (mode)
      MODE_DRAIN: begin
        if (!ck) begin
          mode_next = MODE_IDLE;
        end
      end
      MODE_RECV: begin
        if (ck != expected_level) begin
          if (wait_count >= timeout_limit) begin
            mode_next       = MODE_IDLE;
            wait_count_next = '0;
          end else begin
            wait_count_next = wait_count + 20'd1;
          end
        end else begin
          wait_count_next     = '0;
          shift_byte_next     = byte_assembled;
          expected_level_next = ~expected_level;
          dibit_count_next    = dibit_count + 2'd1;
          if (dibit_count == 2'd3) begin
            shift_byte_next     = '0;
            expected_level_next = 1'b0;
            if (header_pending) begin
              header_pending_next = 1'b0;
              frame_length_next   = byte_assembled;
              bytes_received_next = '0;
              if (byte_assembled == '0) begin
                mode_next = MODE_DRAIN;
              end
            end else begin
              bytes_received_next = bytes_received + 8'd1;
              if (is_last) begin
                mode_next = MODE_DRAIN;
              end
            end
          end
        end
      end
      default: begin
        // Idle, and the unused mode code: a high clock arms the receiver.
        if (ck) begin
          mode_next           = MODE_RECV;
          expected_level_next = 1'b0;
          dibit_count_next    = '0;
          shift_byte_next     = '0;
          header_pending_next = 1'b1;
          frame_length_next   = '0;
          bytes_received_next = '0;
          wait_count_next     = '0;
        end
      end
    endcase
  end

  // Result produced by the sample at the input.
  always_comb begin
    result_fire = 1'b0;
    result_new  = '0;
    case (mode)
      MODE_RECV: begin
        if (ck != expected_level) begin
          if (wait_count >= timeout_limit) begin
            result_fire     = 1'b1;
            result_new.kind = KIND_TIMEOUT;
          end
        end else if (dibit_count == 2'd3) begin
          if (header_pending) begin
            if (byte_assembled == '0) begin
              result_fire     = 1'b1;
              result_new.kind = KIND_EMPTY;
            end
          end else begin
            result_fire           = 1'b1;
            result_new.kind       = KIND_DATA;
            result_new.data_byte  = byte_assembled;
            result_new.byte_index = bytes_received;
            result_new.last       = is_last;
          end
        end
      end
      default: begin
        result_fire = 1'b0;
      end
    endcase
  end

  // Frame state registers, updated on each accepted sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      expected_level <= 1'b0;
      dibit_count    <= '0;
      shift_byte     <= '0;
      header_pending <= 1'b1;
      frame_length   <= '0;
      bytes_received <= '0;
      wait_count     <= '0;
    end else if (s_fire) begin
      mode           <= mode_next;
      expected_level <= expected_level_next;
      dibit_count    <= dibit_count_next;
      shift_byte     <= shift_byte_next;
      header_pending <= header_pending_next;
      frame_length   <= frame_length_next;
      bytes_received <= bytes_received_next;
      wait_count     <= wait_count_next;
    end
  end

  // Output register with one skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_fire) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (s_fire && result_fire) begin
      if (out_valid && !m_fire) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (m_fire) begin
      out_valid <= 1'b0;
    end
  end

  // Output and skid payload.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_fire) begin
        out_reg <= skid_reg;
      end
    end else if (s_fire && result_fire) begin
      if (out_valid && !m_fire) begin
        skid_reg <= result_new;
      end else begin
        out_reg <= result_new;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_reg.byte_index, out_reg.data_byte};
  assign m_axis_tuser  = out_reg.kind;
  assign m_axis_tlast  = out_reg.last;

endmodule

// ===== src/dcfr_checker.sv =====
// Port-level checks for the dibit clocked frame receiver, bound to its top level.
`timescale 1ns / 1ps

module dcfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast,
  input logic        cfg_ready
);
  import dcfr_pkg::*;

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result transaction dropped while stalled");

  // Only data results carry a byte, an index or the last flag.
  a_nondata_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != KIND_DATA |-> m_axis_tdata == '0 && !m_axis_tlast)
    else $error("non-data result carries payload");

  // Kind is one of the three defined codes.
  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser == KIND_DATA || m_axis_tuser == KIND_EMPTY ||
                      m_axis_tuser == KIND_TIMEOUT)
    else $error("result kind out of range");

  // Input is refused only while a result waits that is not taken.
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && $past(m_axis_tvalid) && $past(!m_axis_tready))
    else $error("input stalled without output backpressure");

  // Reset empties the result side and keeps the configuration port open.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && cfg_ready)
    else $error("result pending after reset");

endmodule

bind dibit_clocked_frame_receiver dcfr_checker u_dcfr_checker (.*);
